@@ hdl/bmf_pkg.sv @@
// Shared types, constants and the reciprocal table of the box mean filter.
package bmf_pkg;

   localparam int PIX_W       = 8;
   localparam int MEAN_W      = 8;
   localparam int OUT_X_W     = 10;
   localparam int OUT_Y_W     = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int KERN_W      = 4;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_KERNEL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               emit;
      logic               frame_end;
      logic [OUT_X_W-1:0] out_x;
      logic [OUT_Y_W-1:0] out_y;
   } item_tag_type;

   // ceil(2^24 / k^2); exact floor division for every window sum that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [KERN_W-1:0] k);
      logic [RECIP_W-1:0] m;
      unique case (k)
         4'd1:    m = 25'd16777216;
         4'd2:    m = 25'd4194304;
         4'd3:    m = 25'd1864136;
         4'd4:    m = 25'd1048576;
         4'd5:    m = 25'd671089;
         4'd6:    m = 25'd466034;
         4'd7:    m = 25'd342393;
         4'd8:    m = 25'd262144;
         4'd9:    m = 25'd207127;
         4'd10:   m = 25'd167773;
         4'd11:   m = 25'd138655;
         4'd12:   m = 25'd116509;
         4'd13:   m = 25'd99274;
         4'd14:   m = 25'd85599;
         4'd15:   m = 25'd74566;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ hdl/bmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bmf_front.sv @@
// Front end: configuration, input transfers, position counters, line store, column sums.
module bmf_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_KERNEL = 7,
   localparam int RMAX  = MAX_KERNEL / 2,
   localparam int KW    = 2 * RMAX + 1,
   localparam int CS_W  = $clog2(((1 << bmf_pkg::PIX_W) - 1) * KW + 1),
   localparam int CNT_W = $clog2(bmf_pkg::QUEUE_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [bmf_pkg::PIX_W-1:0]       req_pixel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [CNT_W-1:0]                q_count,
   output logic                            q_push,
   output bmf_pkg::item_tag_type           q_tag,
   output logic [CS_W-1:0]                 q_colsum,
   output logic [KW-1:0]                   q_xmask,
   output logic [bmf_pkg::KERN_W-1:0]      kern
);

   localparam int ROWS   = KW;
   localparam int SLOT_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WE_W   = $clog2(MAX_WIDTH + 1);
   localparam int HE_W   = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + RMAX + 2);
   localparam int OY_W   = $clog2(MAX_HEIGHT);
   localparam int R_W    = (RMAX > 0) ? $clog2(RMAX + 1) : 1;
   localparam int LIN_W  = $clog2(MAX_WIDTH * (MAX_HEIGHT + RMAX + 1) + 1);

   function automatic logic [WE_W-1:0] clamp_w(input logic [10:0] v);
      logic [WE_W-1:0] res;
      if (v == '0) res = WE_W'(1);
      else if (int'(v) > MAX_WIDTH) res = WE_W'(MAX_WIDTH);
      else res = WE_W'(v);
      return res;
   endfunction

   function automatic logic [HE_W-1:0] clamp_h(input logic [12:0] v);
      logic [HE_W-1:0] res;
      if (v == '0) res = HE_W'(1);
      else if (int'(v) > MAX_HEIGHT) res = HE_W'(MAX_HEIGHT);
      else res = HE_W'(v);
      return res;
   endfunction

   function automatic logic [bmf_pkg::KERN_W-1:0] clamp_k(input logic [2:0] v);
      logic [bmf_pkg::KERN_W-1:0] res;
      if (v == '0) res = bmf_pkg::KERN_W'(1);
      else if (int'(v) > MAX_KERNEL) res = bmf_pkg::KERN_W'(MAX_KERNEL);
      else res = bmf_pkg::KERN_W'(v);
      return res;
   endfunction

   // configuration
   logic [WE_W-1:0]            w_ff, w_in;
   logic [HE_W-1:0]            h_ff, h_in;
   logic [bmf_pkg::KERN_W-1:0] k_ff, k_in;
   logic [R_W-1:0]             r_ff, r_in;
   logic [LIN_W-1:0]           rw_ff, rw_in;
   logic [LIN_W-1:0]           lag_ff, lag_in;
   logic                       cfg_hit;

   // stream position
   logic [COL_W-1:0]  vcol_ff, vcol_in;
   logic [ROW_W-1:0]  vrow_ff, vrow_in;
   logic [SLOT_W-1:0] vslot_ff, vslot_in;
   logic [LIN_W-1:0]  vlin_ff, vlin_in;
   logic [COL_W-1:0]  ox_ff, ox_in;
   logic [OY_W-1:0]   oy_ff, oy_in;
   logic              taken_ff, taken_in;

   logic req_fire, act, wr_pix, push, emit, room, fill;
   logic col_last, row_last, ox_last, oy_last, frame_done;
   logic [KW-1:0] ymask, xmask;

   // second stage: line store data arrives here
   logic                      s1_valid_ff;
   logic                      s1_emit_ff;
   logic                      s1_fe_ff;
   logic [bmf_pkg::OUT_X_W-1:0] s1_x_ff;
   logic [bmf_pkg::OUT_Y_W-1:0] s1_y_ff;
   logic [bmf_pkg::PIX_W-1:0] s1_pix_ff;
   logic [KW-1:0]             s1_ymask_ff;
   logic [KW-1:0]             s1_xmask_ff;
   logic [SLOT_W-1:0]         s1_slot_ff;
   logic [CS_W-1:0]           colsum;

   logic [bmf_pkg::PIX_W-1:0] rd_data [ROWS];

   assign csr_ready = 1'b1;
   assign room      = (int'(q_count) + int'(s1_valid_ff)) < bmf_pkg::QUEUE_DEPTH;
   // frame taken but the window lags beyond its end: step through the padding alone
   assign fill      = taken_ff && (vlin_ff < lag_ff);
   assign req_ready = room && !fill;
   assign kern      = k_ff;

   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      k_in    = k_ff;
      cfg_hit = 1'b0;
      if (csr_valid) begin
         unique case (bmf_pkg::csr_index_type'(csr_index))
            bmf_pkg::CSR_WIDTH: begin
               w_in    = clamp_w(csr_wdata[10:0]);
               cfg_hit = 1'b1;
            end
            bmf_pkg::CSR_HEIGHT: begin
               h_in    = clamp_h(csr_wdata[12:0]);
               cfg_hit = 1'b1;
            end
            bmf_pkg::CSR_KERNEL: begin
               k_in    = clamp_k(csr_wdata[2:0]);
               cfg_hit = 1'b1;
            end
            default: ;
         endcase
      end
      r_in   = R_W'(k_in >> 1);
      rw_in  = LIN_W'(r_in) * LIN_W'(w_in);
      lag_in = rw_in + LIN_W'(r_in);
   end

   always_comb begin
      req_fire   = req_valid && req_ready;
      act        = (req_fire && (req_func ? taken_ff : !taken_ff)) || (fill && room);
      wr_pix     = req_fire && !req_func && !taken_ff;
      push       = act && (vlin_ff >= rw_ff);
      emit       = act && (vlin_ff >= lag_ff);
      col_last   = (WE_W'(vcol_ff) + WE_W'(1)) == w_ff;
      row_last   = (vrow_ff + ROW_W'(1)) == ROW_W'(h_ff);
      ox_last    = (WE_W'(ox_ff) + WE_W'(1)) == w_ff;
      oy_last    = (HE_W'(oy_ff) + HE_W'(1)) == h_ff;
      frame_done = emit && ox_last && oy_last;

      vcol_in  = vcol_ff;
      vrow_in  = vrow_ff;
      vslot_in = vslot_ff;
      vlin_in  = vlin_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      taken_in = taken_ff;
      if (act) begin
         if (col_last) begin
            vcol_in  = '0;
            vrow_in  = vrow_ff + ROW_W'(1);
            vslot_in = (vslot_ff == SLOT_W'(ROWS - 1)) ? '0 : vslot_ff + SLOT_W'(1);
         end else begin
            vcol_in = vcol_ff + COL_W'(1);
         end
         vlin_in = vlin_ff + LIN_W'(1);
      end
      if (wr_pix && col_last && row_last) begin
         taken_in = 1'b1;
      end
      if (emit) begin
         if (ox_last) begin
            ox_in = '0;
            oy_in = oy_ff + OY_W'(1);
         end else begin
            ox_in = ox_ff + COL_W'(1);
         end
      end
      if (frame_done || cfg_hit) begin
         vcol_in  = '0;
         vrow_in  = '0;
         vslot_in = '0;
         vlin_in  = '0;
         ox_in    = '0;
         oy_in    = '0;
         taken_in = 1'b0;
      end
   end

   // row d above the current input row is inside the window and the frame
   always_comb begin
      for (int d = 0; d < KW; d++) begin
         ymask[d] = (d <= 2 * int'(r_ff)) && (int'(vrow_ff) >= d)
                    && ((int'(vrow_ff) - d) < int'(h_ff));
      end
   end

   // window slot j holds column ox + r - j
   always_comb begin
      for (int j = 0; j < KW; j++) begin
         xmask[j] = (j <= 2 * int'(r_ff)) && ((int'(ox_ff) + int'(r_ff)) >= j)
                    && ((int'(ox_ff) + int'(r_ff) - j) < int'(w_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= clamp_w(11'd1024);
         h_ff        <= clamp_h(13'd768);
         k_ff        <= clamp_k(3'd3);
         r_ff        <= R_W'(clamp_k(3'd3) >> 1);
         rw_ff       <= LIN_W'(clamp_k(3'd3) >> 1) * LIN_W'(clamp_w(11'd1024));
         lag_ff      <= LIN_W'(clamp_k(3'd3) >> 1) * LIN_W'(clamp_w(11'd1024))
                        + LIN_W'(clamp_k(3'd3) >> 1);
         vcol_ff     <= '0;
         vrow_ff     <= '0;
         vslot_ff    <= '0;
         vlin_ff     <= '0;
         ox_ff       <= '0;
         oy_ff       <= '0;
         taken_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            w_ff   <= w_in;
            h_ff   <= h_in;
            k_ff   <= k_in;
            r_ff   <= r_in;
            rw_ff  <= rw_in;
            lag_ff <= lag_in;
         end
         vcol_ff     <= vcol_in;
         vrow_ff     <= vrow_in;
         vslot_ff    <= vslot_in;
         vlin_ff     <= vlin_in;
         ox_ff       <= ox_in;
         oy_ff       <= oy_in;
         taken_ff    <= taken_in;
         s1_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_emit_ff  <= emit;
         s1_fe_ff    <= frame_done;
         s1_x_ff     <= bmf_pkg::OUT_X_W'(ox_ff);
         s1_y_ff     <= bmf_pkg::OUT_Y_W'(oy_ff);
         s1_pix_ff   <= req_pixel;
         s1_ymask_ff <= ymask;
         s1_xmask_ff <= xmask;
         s1_slot_ff  <= vslot_ff;
      end
   end

   // one line store row per RAM; the current row is written while older rows are read
   for (genvar g = 0; g < ROWS; g++) begin : g_row
      bmf_ram #(
         .WIDTH (bmf_pkg::PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_row (
         .clock   (clock),
         .wr_en   (wr_pix && (vslot_ff == SLOT_W'(g))),
         .wr_addr (vcol_ff),
         .wr_data (req_pixel),
         .rd_addr (vcol_ff),
         .rd_data (rd_data[g])
      );
   end

   // bottom of the column is the incoming pixel, rows above come from the store
   always_comb begin
      int sel;
      sel    = 0;
      colsum = s1_ymask_ff[0] ? CS_W'(s1_pix_ff) : '0;
      for (int d = 1; d < KW; d++) begin
         sel = (int'(s1_slot_ff) >= d) ? int'(s1_slot_ff) - d : int'(s1_slot_ff) + ROWS - d;
         if (s1_ymask_ff[d]) begin
            colsum = colsum + CS_W'(rd_data[SLOT_W'(sel)]);
         end
      end
   end

   assign q_push          = s1_valid_ff;
   assign q_tag.emit      = s1_emit_ff;
   assign q_tag.frame_end = s1_fe_ff;
   assign q_tag.out_x     = s1_x_ff;
   assign q_tag.out_y     = s1_y_ff;
   assign q_colsum        = colsum;
   assign q_xmask         = s1_xmask_ff;

endmodule

@@ hdl/bmf_queue.sv @@
// Short register FIFO between front and back ends.
module bmf_queue #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data,
   output logic [CNT_W-1:0]  count
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/bmf_back.sv @@
// Back end: sliding window of column sums, window total, multiply by reciprocal, output register.
module bmf_back #(
   parameter int MAX_KERNEL = 7,
   localparam int RMAX = MAX_KERNEL / 2,
   localparam int KW   = 2 * RMAX + 1,
   localparam int CS_W = $clog2(((1 << bmf_pkg::PIX_W) - 1) * KW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  bmf_pkg::item_tag_type         q_tag,
   input  logic [CS_W-1:0]               q_colsum,
   input  logic [KW-1:0]                 q_xmask,
   input  logic [bmf_pkg::KERN_W-1:0]    kern,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_mean,
   output logic [bmf_pkg::OUT_X_W-1:0]   rsp_out_x,
   output logic [bmf_pkg::OUT_Y_W-1:0]   rsp_out_y,
   output logic                          rsp_frame_end
);

   localparam int SUM_W  = $clog2(((1 << bmf_pkg::PIX_W) - 1) * KW * KW + 1);
   localparam int PROD_W = SUM_W + bmf_pkg::RECIP_W;
   localparam int QUO_W  = PROD_W - bmf_pkg::RECIP_SHIFT;
   localparam int MEAN_MAX = (1 << bmf_pkg::MEAN_W) - 1;

   logic [CS_W-1:0] win_ff [KW];
   logic [CS_W-1:0] win_in [KW];
   logic [SUM_W-1:0] sum;

   logic                  out_en, b2_en, b1_en, pop;
   logic                  b1_valid_ff, b2_valid_ff, rsp_valid_ff;
   bmf_pkg::item_tag_type b1_tag_ff, b2_tag_ff;
   logic [SUM_W-1:0]      b1_sum_ff;
   logic [PROD_W-1:0]     b2_prod_ff;
   logic [QUO_W-1:0]      quo;
   logic [bmf_pkg::MEAN_W-1:0] mean;
   logic [bmf_pkg::MEAN_W-1:0] rsp_mean_ff;
   logic [bmf_pkg::OUT_X_W-1:0] rsp_x_ff;
   logic [bmf_pkg::OUT_Y_W-1:0] rsp_y_ff;
   logic                  rsp_fe_ff;

   assign out_en = !rsp_valid_ff || rsp_ready;
   assign b2_en  = !b2_valid_ff || out_en;
   assign b1_en  = !b1_valid_ff || b2_en;
   assign pop    = q_valid && b1_en;
   assign q_pop  = pop;

   // new column enters at slot 0; columns outside the frame are masked off
   always_comb begin
      win_in[0] = q_colsum;
      for (int j = 1; j < KW; j++) begin
         win_in[j] = win_ff[j-1];
      end
      sum = '0;
      for (int j = 0; j < KW; j++) begin
         if (q_xmask[j]) sum = sum + SUM_W'(win_in[j]);
      end
   end

   assign quo  = b2_prod_ff[PROD_W-1:bmf_pkg::RECIP_SHIFT];
   assign mean = (int'(quo) > MEAN_MAX) ? bmf_pkg::MEAN_W'(MEAN_MAX) : bmf_pkg::MEAN_W'(quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b1_en) b1_valid_ff <= pop && q_tag.emit;
         if (b2_en) b2_valid_ff <= b1_valid_ff;
         if (out_en) rsp_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int j = 0; j < KW; j++) begin
            win_ff[j] <= win_in[j];
         end
      end
      if (b1_en && pop) begin
         b1_tag_ff <= q_tag;
         b1_sum_ff <= sum;
      end
      if (b2_en && b1_valid_ff) begin
         b2_tag_ff  <= b1_tag_ff;
         b2_prod_ff <= PROD_W'(b1_sum_ff) * PROD_W'(bmf_pkg::recip(kern));
      end
      if (out_en && b2_valid_ff) begin
         rsp_mean_ff <= mean;
         rsp_x_ff    <= b2_tag_ff.out_x;
         rsp_y_ff    <= b2_tag_ff.out_y;
         rsp_fe_ff   <= b2_tag_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean      = rsp_mean_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_frame_end = rsp_fe_ff;

endmodule

@@ hdl/box_mean_filter_stream_top.sv @@
// Top level of the streaming zero-padded box mean filter.
//
//   channel   direction  transfer carries
//   req_*     in         func (pixel or drain), pixel
//   rsp_*     out        mean, out_x, out_y, frame_end
//   csr_*     in         index (width, height, kernel), wdata
//
// One item per clock sustained while req_ready stays high; the transfer that releases
// an item passes line store read, column sum, queue, window sum, multiply and output.
// The rate is set by the line store: one RAM per kept row, written and read once a cycle.
// Synchronous reset; no clearing pass, rows are only read where already written.
// req_ready drops when the 4-entry queue has no room; rsp stalls back up into the queue.
// When the window lag exceeds the frame, req_ready stays low after the last pixel
// while the window steps through the padding.
module box_mean_filter_stream_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_KERNEL = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [bmf_pkg::PIX_W-1:0]      req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bmf_pkg::MEAN_W-1:0]     rsp_mean,
   output logic [bmf_pkg::OUT_X_W-1:0]    rsp_out_x,
   output logic [bmf_pkg::OUT_Y_W-1:0]    rsp_out_y,
   output logic                           rsp_frame_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int RMAX   = MAX_KERNEL / 2;
   localparam int KW     = 2 * RMAX + 1;
   localparam int CS_W   = $clog2(((1 << bmf_pkg::PIX_W) - 1) * KW + 1);
   localparam int CNT_W  = $clog2(bmf_pkg::QUEUE_DEPTH + 1);
   localparam int TAG_W  = $bits(bmf_pkg::item_tag_type);
   localparam int ITEM_W = TAG_W + KW + CS_W;

   logic                       q_push, q_pop, q_valid;
   logic [CNT_W-1:0]           q_count;
   bmf_pkg::item_tag_type      f_tag, b_tag;
   logic [CS_W-1:0]            f_colsum, b_colsum;
   logic [KW-1:0]              f_xmask, b_xmask;
   logic [ITEM_W-1:0]          q_wr, q_rd;
   logic [bmf_pkg::KERN_W-1:0] kern;

   bmf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_pixel (req_pixel),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_tag     (f_tag),
      .q_colsum  (f_colsum),
      .q_xmask   (f_xmask),
      .kern      (kern)
   );

   assign q_wr = {f_tag, f_xmask, f_colsum};
   assign b_tag    = q_rd[ITEM_W-1 -: TAG_W];
   assign b_xmask  = q_rd[CS_W +: KW];
   assign b_colsum = q_rd[CS_W-1:0];

   bmf_queue #(
      .DATA_W (ITEM_W),
      .DEPTH  (bmf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rd),
      .count     (q_count)
   );

   bmf_back #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_tag         (b_tag),
      .q_colsum      (b_colsum),
      .q_xmask       (b_xmask),
      .kern          (kern),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_mean      (rsp_mean),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

@@ hdl/bmf_checker.sv @@
// Port-level checks of the box mean filter top level, bound to it.
module bmf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_func,
   input logic [bmf_pkg::PIX_W-1:0]      req_pixel,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bmf_pkg::MEAN_W-1:0]     rsp_mean,
   input logic [bmf_pkg::OUT_X_W-1:0]    rsp_out_x,
   input logic [bmf_pkg::OUT_Y_W-1:0]    rsp_out_y,
   input logic                           rsp_frame_end,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [bmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [bmf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean) && $stable(rsp_out_x)
                                  && $stable(rsp_out_y) && $stable(rsp_frame_end))
      else $error("rsp payload changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle straight after reset");

   a_req_stable: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_func) && $stable(req_pixel))
      else $error("req transfer changed while waiting");

   a_csr_stable: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !csr_ready |=> csr_valid && $stable(csr_index) && $stable(csr_wdata))
      else $error("csr transfer changed while waiting");

endmodule

bind box_mean_filter_stream_top bmf_checker u_bmf_checker (.*);
